@@ design/cdeq_pkg.sv @@
// ----------------------------------------------------------------------------
// cdeq_pkg
// Shared types, constants and index helpers for the circular deque.
// ----------------------------------------------------------------------------
`default_nettype none

package cdeq_pkg;

  localparam int DEPTH      = 16;
  localparam int DATA_WIDTH = 32;
  localparam int IDX_W      = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CAP_W      = $clog2(DEPTH + 1);

  // command codes
  localparam logic [1:0] CMD_PUSH_FRONT = 2'd0;
  localparam logic [1:0] CMD_PUSH_REAR  = 2'd1;
  localparam logic [1:0] CMD_POP_FRONT  = 2'd2;
  localparam logic [1:0] CMD_POP_REAR   = 2'd3;

  // status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_OVERFLOW  = 2'd1;
  localparam logic [1:0] ST_UNDERFLOW = 2'd2;

  // source of the popped value in a result item
  typedef enum logic [1:0] {
    VAL_ZERO = 2'd0,
    VAL_ONES = 2'd1,
    VAL_READ = 2'd2
  } val_sel_t;

  typedef struct packed {
    logic [1:0]            command;
    logic signed [31:0]    push_value;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0]    popped_value;
    logic [1:0]            status;
    logic                  now_empty;
  } out_item_t;

  // control broadcast along the cell row
  typedef struct packed {
    logic             wr_en;
    logic [IDX_W-1:0] wr_idx;
    logic [IDX_W-1:0] rd_idx;
  } cell_ctl_t;

  // result control from the index unit
  typedef struct packed {
    val_sel_t   val_sel;
    logic [1:0] status;
    logic       now_empty;
  } res_ctl_t;

  // step an index forward, wrapping at the capacity
  function automatic logic [IDX_W-1:0] step_up(input logic [IDX_W-1:0] idx,
                                               input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] nxt;
    nxt = {{(CAP_W+1-IDX_W){1'b0}}, idx} + {{CAP_W{1'b0}}, 1'b1};
    if (nxt >= {1'b0, cap}) begin
      return '0;
    end
    return IDX_W'(nxt);
  endfunction

  // step an index back, wrapping to the last used entry
  function automatic logic [IDX_W-1:0] step_down(input logic [IDX_W-1:0] idx,
                                                 input logic [CAP_W-1:0] cap);
    logic [CAP_W:0] wide;
    wide = {{(CAP_W+1-IDX_W){1'b0}}, idx};
    if (idx == '0 || wide > {1'b0, cap}) begin
      return IDX_W'(cap - CAP_W'(1));
    end
    return idx - IDX_W'(1);
  endfunction

endpackage

`default_nettype wire

@@ design/cdeq_cell.sv @@
// ----------------------------------------------------------------------------
// cdeq_cell
// One storage cell of the deque row: holds one element, writes it when
// addressed, and passes the read bus on to its neighbor.
// ----------------------------------------------------------------------------
`default_nettype none

module cdeq_cell
  import cdeq_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic [IDX_W-1:0]      cell_idx,
  input  wire cell_ctl_t             ctl,
  input  wire logic [DATA_WIDTH-1:0] wr_data,
  input  wire logic [DATA_WIDTH-1:0] rd_in,
  output logic [DATA_WIDTH-1:0]      rd_out
);

  logic [DATA_WIDTH-1:0] data_r;

  // capture the element when this cell is addressed
  always_ff @(posedge clk) begin
    if (ctl.wr_en && ctl.wr_idx == cell_idx) begin
      data_r <= wr_data;
    end
  end

  // drive the read bus when selected, else pass the neighbor's value
  assign rd_out = (ctl.rd_idx == cell_idx) ? data_r : rd_in;

endmodule

`default_nettype wire

@@ design/cdeq_ctrl.sv @@
// ----------------------------------------------------------------------------
// cdeq_ctrl
// Head/tail index unit: holds the indices, empty mark and capacity, and
// decides per item which cell to write or read and what to report.
// ----------------------------------------------------------------------------
`default_nettype none

module cdeq_ctrl
  import cdeq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_cap,
  input  wire logic             item_go,
  input  wire logic [1:0]       command,
  output cell_ctl_t             cell_ctl,
  output res_ctl_t              res_ctl
);

  logic [IDX_W-1:0] head_r, head_nxt;
  logic [IDX_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [CAP_W-1:0] cap_r;
  logic [CAP_W-1:0] cap_eff;
  logic             full;
  logic             is_push;

  // clamp the capacity to 1..DEPTH
  always_comb begin
    if (cap_r == '0) begin
      cap_eff = CAP_W'(1);
    end else if (cap_r > CAP_W'(DEPTH)) begin
      cap_eff = CAP_W'(DEPTH);
    end else begin
      cap_eff = cap_r;
    end
  end

  assign is_push = (command == CMD_PUSH_FRONT) || (command == CMD_PUSH_REAR);
  assign full    = !empty_r && (step_up(tail_r, cap_eff) == head_r);

  // work out next indices, cell access and result
  always_comb begin
    head_nxt         = head_r;
    tail_nxt         = tail_r;
    empty_nxt        = empty_r;
    cell_ctl.wr_en   = 1'b0;
    cell_ctl.wr_idx  = '0;
    cell_ctl.rd_idx  = head_r;
    res_ctl.val_sel  = VAL_ZERO;
    res_ctl.status   = ST_OK;

    if (is_push) begin
      if (full) begin
        res_ctl.status = ST_OVERFLOW;
      end else if (empty_r) begin
        head_nxt       = '0;
        tail_nxt       = '0;
        empty_nxt      = 1'b0;
        cell_ctl.wr_en = 1'b1;
      end else if (command == CMD_PUSH_FRONT) begin
        head_nxt        = step_down(head_r, cap_eff);
        cell_ctl.wr_en  = 1'b1;
        cell_ctl.wr_idx = head_nxt;
      end else begin
        tail_nxt        = step_up(tail_r, cap_eff);
        cell_ctl.wr_en  = 1'b1;
        cell_ctl.wr_idx = tail_nxt;
      end
    end else begin
      if (empty_r) begin
        res_ctl.status  = ST_UNDERFLOW;
        res_ctl.val_sel = VAL_ONES;
      end else begin
        res_ctl.val_sel = VAL_READ;
        cell_ctl.rd_idx = (command == CMD_POP_FRONT) ? head_r : tail_r;
        if (head_r == tail_r) begin
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b1;
        end else if (command == CMD_POP_FRONT) begin
          head_nxt = step_up(head_r, cap_eff);
        end else begin
          tail_nxt = step_down(tail_r, cap_eff);
        end
      end
    end

    // drop writes unless an item is actually taken
    if (!item_go) begin
      cell_ctl.wr_en = 1'b0;
    end
    res_ctl.now_empty = empty_nxt;
  end

  // advance state on each accepted item; load the capacity on a config write
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r  <= '0;
      tail_r  <= '0;
      empty_r <= 1'b1;
      cap_r   <= CAP_W'(DEPTH);
    end else begin
      if (cfg_we) begin
        cap_r <= cfg_cap;
      end
      if (item_go) begin
        head_r  <= head_nxt;
        tail_r  <= tail_nxt;
        empty_r <= empty_nxt;
      end
    end
  end

endmodule

`default_nettype wire

@@ design/circular_double_ended_queue.sv @@
// ----------------------------------------------------------------------------
// circular_double_ended_queue
// Double-ended queue over a row of storage cells, with wrap at a
// configurable capacity and one result item per command item.
// ----------------------------------------------------------------------------
//   channel | ports                         | payload
//   --------+-------------------------------+---------------------------------
//   input   | in_valid / in_ready / in_data | command, push_value
//   result  | out_valid/out_ready/out_data  | popped_value, status, now_empty
//   config  | cfg_valid/cfg_ready/cfg_data  | capacity_in_use (5 bits)
//
// One item per cycle while the result side is not stalled: index update,
// cell write and cell read all finish in the cycle the item is taken; the
// result lands in the output register. A stalled result holds the input side
// only while the output register is full and out_ready is low.
// Synchronous reset empties the queue and sets the capacity to 16; stored
// elements are not cleared. cfg_ready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module circular_double_ended_queue
  import cdeq_pkg::*;
(
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_valid,
  output logic                  in_ready,
  input  wire in_item_t         in_data,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output out_item_t             out_data,
  input  wire logic             cfg_valid,
  output logic                  cfg_ready,
  input  wire logic [CAP_W-1:0] cfg_data
);

  cell_ctl_t             cell_ctl;
  res_ctl_t              res_ctl;
  logic                  item_go;
  logic [DATA_WIDTH-1:0] rd_chain [DEPTH+1];
  logic [DATA_WIDTH-1:0] pop_val;
  out_item_t             out_r;
  logic                  out_valid_r;

  assign cfg_ready = 1'b1;
  assign in_ready  = !out_valid_r || out_ready;
  assign item_go   = in_valid && in_ready;

  cdeq_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_valid),
    .cfg_cap  (cfg_data),
    .item_go  (item_go),
    .command  (in_data.command),
    .cell_ctl (cell_ctl),
    .res_ctl  (res_ctl)
  );

  // row of storage cells; the read bus ripples from cell to cell
  assign rd_chain[0] = '0;
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    cdeq_cell u_cell (
      .clk      (clk),
      .cell_idx (IDX_W'(i)),
      .ctl      (cell_ctl),
      .wr_data  (DATA_WIDTH'(in_data.push_value)),
      .rd_in    (rd_chain[i]),
      .rd_out   (rd_chain[i+1])
    );
  end

  // select the popped value
  always_comb begin
    case (res_ctl.val_sel)
      VAL_ONES: pop_val = '1;
      VAL_READ: pop_val = rd_chain[DEPTH];
      default:  pop_val = '0;
    endcase
  end

  // hold the result until taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_go) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_go) begin
      out_r.popped_value <= 32'(pop_val);
      out_r.status       <= res_ctl.status;
      out_r.now_empty    <= res_ctl.now_empty;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_r;

endmodule

`default_nettype wire
